@@ rtl/sled_pkg.sv @@
// ----------------------------------------------------------------------------
// Status LED driver package
// Shared codes, colour words, configuration structs and a helper function.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int COLOUR_BITS = 24;
    localparam int TICK_W      = 15;
    localparam int PERIOD_W    = 16;
    localparam int MODE_W      = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SYM_IDX_W   = $clog2(COLOUR_BITS + 1);
    localparam int DIV_STEPS   = PERIOD_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MODE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_OFF        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCANNING   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONNECTING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CONNECTED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READY      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON     = 3'd6;

    // Colour words in GRB order.
    localparam logic [COLOUR_BITS-1:0] GRB_BLACK  = 24'h000000;
    localparam logic [COLOUR_BITS-1:0] GRB_BLUE   = 24'h0000FF;
    localparam logic [COLOUR_BITS-1:0] GRB_YELLOW = 24'hFFFF00;
    localparam logic [COLOUR_BITS-1:0] GRB_GREEN  = 24'hFF0000;
    localparam logic [COLOUR_BITS-1:0] GRB_RED    = 24'h00FF00;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch_low;
    } pulse_cfg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] on_ticks;
    } blink_cfg_t;

    function automatic logic [COLOUR_BITS-1:0] mode_colour(
        input logic [MODE_W-1:0] mode,
        input logic              lit
    );
        logic [COLOUR_BITS-1:0] word;
        if (!lit) begin
            word = GRB_BLACK;
        end
        else if (mode == MODE_SCANNING) begin
            word = GRB_BLUE;
        end
        else if (mode == MODE_CONNECTING) begin
            word = GRB_YELLOW;
        end
        else begin
            word = GRB_GREEN;
        end
        return word;
    endfunction

endpackage

@@ rtl/status_led_blink_rgb_pulse_driver.sv @@
// ----------------------------------------------------------------------------
// Status LED blink and RGB pulse driver
// Top level: configuration registers, front end, frame queue and serializer.
//
//  Channel   Direction  Handshake        Beat
//  input     in         push / full      one tick, mode change or colour
//  result    out        empty / pop      one line symbol (two timed halves)
//  config    in         cfg_we           one register write, no wait
//
// Each colour frame gives 25 symbols, one per cycle while pop is held, set by the serializer.
// A tick whose counter wrap needs a true remainder holds full high while the
// front end runs its bit-serial remainder unit.
// The frame queue lets new beats enter while earlier frames are still sent.
// Reset is asynchronous: mode off, counter zero, registers at their defaults.
// A stalled pop holds the current symbol; the serializer then waits.
// ----------------------------------------------------------------------------
module status_led_blink_rgb_pulse_driver
    import sled_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [KIND_W-1:0]     kind,
    input  logic                  link_ready,
    input  logic [MODE_W-1:0]     new_mode,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    output logic                  empty,
    input  logic                  pop,
    output logic                  first_level,
    output logic [TICK_W-1:0]     first_ticks,
    output logic                  second_level,
    output logic [TICK_W-1:0]     second_ticks,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    pulse_cfg_t             pulse_cfg_reg;
    blink_cfg_t             blink_cfg_reg;
    logic                   front_busy;
    logic                   q_push;
    logic [COLOUR_BITS-1:0] q_wr_data;
    logic [COLOUR_BITS-1:0] q_rd_data;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_cfg_reg.zero_high <= 15'd3;
            pulse_cfg_reg.zero_low  <= 15'd9;
            pulse_cfg_reg.one_high  <= 15'd6;
            pulse_cfg_reg.one_low   <= 15'd6;
            pulse_cfg_reg.latch_low <= 15'd500;
            blink_cfg_reg.period    <= 16'd200;
            blink_cfg_reg.on_ticks  <= 16'd40;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ZERO_HIGH:    pulse_cfg_reg.zero_high <= cfg_wdata[TICK_W-1:0];
                CFG_ZERO_LOW:     pulse_cfg_reg.zero_low  <= cfg_wdata[TICK_W-1:0];
                CFG_ONE_HIGH:     pulse_cfg_reg.one_high  <= cfg_wdata[TICK_W-1:0];
                CFG_ONE_LOW:      pulse_cfg_reg.one_low   <= cfg_wdata[TICK_W-1:0];
                CFG_LATCH_LOW:    pulse_cfg_reg.latch_low <= cfg_wdata[TICK_W-1:0];
                CFG_BLINK_PERIOD: blink_cfg_reg.period    <= cfg_wdata[PERIOD_W-1:0];
                CFG_BLINK_ON:     blink_cfg_reg.on_ticks  <= cfg_wdata[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full = front_busy || q_full;

    sled_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (push && !full),
        .kind       (kind),
        .link_ready (link_ready),
        .new_mode   (new_mode),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .blink_cfg  (blink_cfg_reg),
        .busy       (front_busy),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    sled_fifo #(
        .WIDTH (COLOUR_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    sled_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pulse_cfg    (pulse_cfg_reg),
        .q_empty      (q_empty),
        .q_data       (q_rd_data),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .first_level  (first_level),
        .first_ticks  (first_ticks),
        .second_level (second_level),
        .second_ticks (second_ticks),
        .last         (last)
    );

    // The latch symbol keeps the line low for its whole length.
    a_latch_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (!first_level && !second_level && second_ticks == '0))
        else $error("latch symbol has a high level or a second half");

    a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (first_level && !second_level))
        else $error("data symbol is not high then low");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("frame queue flags full and empty together");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        front_busy |-> full)
        else $error("input taken while the remainder unit runs");

endmodule

@@ rtl/sled_fifo.sv @@
// ----------------------------------------------------------------------------
// Status LED frame queue
// Small first-in first-out queue of colour words between front and back.
// ----------------------------------------------------------------------------
module sled_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/sled_front.sv @@
// ----------------------------------------------------------------------------
// Status LED front end
// Takes input beats, keeps status mode and blink counter, and queues the
// colour word of every frame to be sent.
// ----------------------------------------------------------------------------
module sled_front
    import sled_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_accept,
    input  logic [KIND_W-1:0]      kind,
    input  logic                   link_ready,
    input  logic [MODE_W-1:0]      new_mode,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  blink_cfg_t             blink_cfg,
    output logic                   busy,
    output logic                   q_push,
    output logic [COLOUR_BITS-1:0] q_data
);

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_DIV  = 2'b10
    } front_state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    front_state_t          state_reg;
    front_state_t          state_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [MODE_W-1:0]     mode_next;
    logic [PERIOD_W-1:0]   count_reg;
    logic [PERIOD_W-1:0]   count_next;
    logic [PERIOD_W:0]     dividend_reg;
    logic [PERIOD_W:0]     dividend_next;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PERIOD_W-1:0]   rem_next;
    logic [DIV_CNT_W-1:0]  step_reg;
    logic [DIV_CNT_W-1:0]  step_next;

    logic                  blinker;
    logic [PERIOD_W:0]     inc;
    logic [PERIOD_W:0]     period_ext;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     reduced;

    assign busy = (state_reg == FS_DIV);

    always_comb
    begin
        blinker    = (mode_reg inside {MODE_SCANNING, MODE_CONNECTING, MODE_CONNECTED});
        inc        = {1'b0, count_reg} + 1'b1;
        period_ext = (blink_cfg.period == '0) ? {1'b1, {PERIOD_W{1'b0}}}
                                              : {1'b0, blink_cfg.period};
        trial      = {rem_reg, dividend_reg[PERIOD_W]};
        reduced    = (trial >= period_ext) ? trial - period_ext : trial;
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        q_push        = 1'b0;
        q_data        = GRB_BLACK;
        case (state_reg)
            FS_IDLE:
            begin
                if (in_accept)
                begin
                    case (kind)
                        KIND_TICK:
                        begin
                            if (link_ready)
                            begin
                                q_push = blinker;
                                q_data = mode_colour(mode_reg, 1'b1);
                            end
                            else if (inc < period_ext)
                            begin
                                count_next = inc[PERIOD_W-1:0];
                                q_push     = blinker;
                                q_data     = mode_colour(mode_reg,
                                    inc[PERIOD_W-1:0] < blink_cfg.on_ticks);
                            end
                            else if (inc == period_ext)
                            begin
                                count_next = '0;
                                q_push     = blinker;
                                q_data     = mode_colour(mode_reg,
                                    blink_cfg.on_ticks != '0);
                            end
                            else
                            begin
                                state_next    = FS_DIV;
                                dividend_next = inc;
                                rem_next      = '0;
                                step_next     = '0;
                            end
                        end
                        KIND_MODE:
                        begin
                            mode_next  = new_mode;
                            count_next = '0;
                            case (new_mode)
                                MODE_OFF:
                                begin
                                    q_push = 1'b1;
                                    q_data = GRB_BLACK;
                                end
                                MODE_CONNECTING:
                                begin
                                    q_push = 1'b1;
                                    q_data = GRB_YELLOW;
                                end
                                MODE_ERROR:
                                begin
                                    q_push = 1'b1;
                                    q_data = GRB_RED;
                                end
                                MODE_READY:
                                begin
                                    q_push = 1'b1;
                                    q_data = GRB_BLUE;
                                end
                                default:
                                begin
                                    q_push = 1'b0;
                                end
                            endcase
                        end
                        KIND_DIRECT:
                        begin
                            q_push = 1'b1;
                            q_data = {green, red, blue};
                        end
                        default:
                        begin
                            q_push = 1'b0;
                        end
                    endcase
                end
            end
            FS_DIV:
            begin
                rem_next      = reduced[PERIOD_W-1:0];
                dividend_next = {dividend_reg[PERIOD_W-1:0], 1'b0};
                step_next     = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = FS_IDLE;
                    count_next = reduced[PERIOD_W-1:0];
                    q_push     = blinker;
                    q_data     = mode_colour(mode_reg,
                        reduced[PERIOD_W-1:0] < blink_cfg.on_ticks);
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            mode_reg  <= MODE_OFF;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
    end

endmodule

@@ rtl/sled_back.sv @@
// ----------------------------------------------------------------------------
// Status LED symbol serializer
// Turns each queued colour word into 24 data symbols and one latch symbol,
// one symbol per cycle while pop is held, into an output register.
// ----------------------------------------------------------------------------
module sled_back
    import sled_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pulse_cfg_t             pulse_cfg,
    input  logic                   q_empty,
    input  logic [COLOUR_BITS-1:0] q_data,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic                   first_level,
    output logic [TICK_W-1:0]      first_ticks,
    output logic                   second_level,
    output logic [TICK_W-1:0]      second_ticks,
    output logic                   last
);

    localparam logic [SYM_IDX_W-1:0] LAST_IDX = SYM_IDX_W'(COLOUR_BITS);

    logic                   active_reg;
    logic                   active_next;
    logic [COLOUR_BITS-1:0] word_reg;
    logic [COLOUR_BITS-1:0] word_next;
    logic [SYM_IDX_W-1:0]   idx_reg;
    logic [SYM_IDX_W-1:0]   idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   first_level_reg;
    logic [TICK_W-1:0]      first_ticks_reg;
    logic                   second_level_reg;
    logic [TICK_W-1:0]      second_ticks_reg;
    logic                   last_reg;

    logic                   taken;
    logic                   emit;
    logic                   at_latch;
    logic                   bit_val;

    assign taken    = pop && out_valid_reg;
    assign emit     = active_reg && (!out_valid_reg || taken);
    assign at_latch = (idx_reg == LAST_IDX);
    assign bit_val  = word_reg[COLOUR_BITS-1];
    assign q_pop    = !q_empty && (!active_reg || (emit && at_latch));

    always_comb
    begin
        active_next    = active_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (taken)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            word_next      = {word_reg[COLOUR_BITS-2:0], 1'b0};
            idx_next       = idx_reg + 1'b1;
            if (at_latch)
            begin
                active_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            active_next = 1'b1;
            word_next   = q_data;
            idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (emit)
        begin
            if (at_latch)
            begin
                first_level_reg  <= 1'b0;
                first_ticks_reg  <= pulse_cfg.latch_low;
                second_level_reg <= 1'b0;
                second_ticks_reg <= '0;
                last_reg         <= 1'b1;
            end
            else
            begin
                first_level_reg  <= 1'b1;
                first_ticks_reg  <= bit_val ? pulse_cfg.one_high : pulse_cfg.zero_high;
                second_level_reg <= 1'b0;
                second_ticks_reg <= bit_val ? pulse_cfg.one_low : pulse_cfg.zero_low;
                last_reg         <= 1'b0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign first_level  = first_level_reg;
    assign first_ticks  = first_ticks_reg;
    assign second_level = second_level_reg;
    assign second_ticks = second_ticks_reg;
    assign last         = last_reg;

endmodule

@@ verif/status_led_blink_rgb_pulse_driver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED blink and RGB pulse driver testbench
// Drives tick, mode and color beats through the push/full queue and pops
// line symbols at random. A scoreboard class keeps its own copy of the mode,
// the blink counter and the timing registers, builds the 25 expected symbols
// of every color frame and checks each popped symbol field by field.
// Register settings are changed only while the block is idle.
// ----------------------------------------------------------------------------
module status_led_blink_rgb_pulse_driver_test
    import sled_pkg::*;
();

    localparam logic [KIND_W-1:0]    KIND_SPARE  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_SPARE7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;
    localparam int HOLD_OFF    = 48;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_BEATS = 66;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_ticks;
        logic              second_level;
        logic [TICK_W-1:0] second_ticks;
        logic              last;
    } led_symbol_t;

    class led_frame_scoreboard;
        logic [TICK_W-1:0]   zero_high;
        logic [TICK_W-1:0]   zero_low;
        logic [TICK_W-1:0]   one_high;
        logic [TICK_W-1:0]   one_low;
        logic [TICK_W-1:0]   latch_low;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] on_ticks;
        logic [MODE_W-1:0]   mode;
        logic [PERIOD_W-1:0] count;
        led_symbol_t         expected_symbols[$];
        int                  errors;
        int                  beats;
        int                  frames;
        int                  symbols_checked;

        function new();
            zero_high = 15'd3;
            zero_low  = 15'd9;
            one_high  = 15'd6;
            one_low   = 15'd6;
            latch_low = 15'd500;
            period    = 16'd200;
            on_ticks  = 16'd40;
            mode      = MODE_OFF;
            count     = '0;
            errors    = 0;
            beats     = 0;
            frames    = 0;
            symbols_checked = 0;
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ZERO_HIGH:    zero_high = data[TICK_W-1:0];
                CFG_ZERO_LOW:     zero_low  = data[TICK_W-1:0];
                CFG_ONE_HIGH:     one_high  = data[TICK_W-1:0];
                CFG_ONE_LOW:      one_low   = data[TICK_W-1:0];
                CFG_LATCH_LOW:    latch_low = data[TICK_W-1:0];
                CFG_BLINK_PERIOD: period    = data;
                CFG_BLINK_ON:     on_ticks  = data;
                default:          ;
            endcase
        endfunction

        function void push_frame(logic [COLOUR_BITS-1:0] grb);
            led_symbol_t sym;
            for (int i = COLOUR_BITS - 1; i >= 0; i--)
            begin
                sym.first_level  = 1'b1;
                sym.first_ticks  = grb[i] ? one_high : zero_high;
                sym.second_level = 1'b0;
                sym.second_ticks = grb[i] ? one_low : zero_low;
                sym.last         = 1'b0;
                expected_symbols.push_back(sym);
            end
            sym.first_level  = 1'b0;
            sym.first_ticks  = latch_low;
            sym.second_level = 1'b0;
            sym.second_ticks = '0;
            sym.last         = 1'b1;
            expected_symbols.push_back(sym);
            frames++;
        endfunction

        function logic [COLOUR_BITS-1:0] blink_colour(logic lit);
            if (!lit)
                return GRB_BLACK;
            if (mode == MODE_SCANNING)
                return GRB_BLUE;
            if (mode == MODE_CONNECTING)
                return GRB_YELLOW;
            return GRB_GREEN;
        endfunction

        function void note_input(logic [KIND_W-1:0] k, logic lk, logic [MODE_W-1:0] m,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic        blinker;
            logic [31:0] wrap;
            logic [31:0] next_count;
            blinker = (mode == MODE_SCANNING) || (mode == MODE_CONNECTING) ||
                      (mode == MODE_CONNECTED);
            beats++;
            case (k)
                KIND_TICK:
                begin
                    if (lk)
                    begin
                        if (blinker)
                            push_frame(blink_colour(1'b1));
                    end
                    else
                    begin
                        wrap = (period == '0) ? 32'd65536 : {16'd0, period};
                        next_count = ({16'd0, count} + 32'd1) % wrap;
                        count = next_count[PERIOD_W-1:0];
                        if (blinker)
                            push_frame(blink_colour(count < on_ticks));
                    end
                end
                KIND_MODE:
                begin
                    mode  = m;
                    count = '0;
                    case (m)
                        MODE_OFF:        push_frame(GRB_BLACK);
                        MODE_CONNECTING: push_frame(GRB_YELLOW);
                        MODE_ERROR:      push_frame(GRB_RED);
                        MODE_READY:      push_frame(GRB_BLUE);
                        default:         ;
                    endcase
                end
                KIND_DIRECT: push_frame({g, r, b});
                default:     ;
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_symbol(logic fl, logic [TICK_W-1:0] ft, logic sl,
                                   logic [TICK_W-1:0] st, logic lst);
            led_symbol_t want;
            if (expected_symbols.size() == 0)
            begin
                $error("Symbol popped with no expected symbol waiting.");
                errors++;
                return;
            end
            want = expected_symbols.pop_front();
            symbols_checked++;
            compare_field("first_level", 16'(want.first_level), 16'(fl));
            compare_field("first_ticks", 16'(want.first_ticks), 16'(ft));
            compare_field("second_level", 16'(want.second_level), 16'(sl));
            compare_field("second_ticks", 16'(want.second_ticks), 16'(st));
            compare_field("last", 16'(want.last), 16'(lst));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [KIND_W-1:0]     kind = KIND_TICK;
    logic                  link_ready = 1'b0;
    logic [MODE_W-1:0]     new_mode = MODE_OFF;
    logic [7:0]            red = '0;
    logic [7:0]            green = '0;
    logic [7:0]            blue = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  first_level;
    logic [TICK_W-1:0]     first_ticks;
    logic                  second_level;
    logic [TICK_W-1:0]     second_ticks;
    logic                  last;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ZERO_HIGH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    led_frame_scoreboard sb = new();
    logic steady = 1'b0;
    int   quiet = 0;
    int   settings_used = 1;

    status_led_blink_rgb_pulse_driver dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        pop <= steady || ($urandom_range(99) >= 32);
    end

    always @(posedge clk)
    begin
        if (push && !full)
            sb.note_input(kind, link_ready, new_mode, red, green, blue);
        if (pop && !empty)
            sb.check_symbol(first_level, first_ticks, second_level, second_ticks, last);
        if ((push && !full) || (pop && !empty) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic lk,
                             input logic [MODE_W-1:0] m, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 32)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        kind       <= k;
        link_ready <= lk;
        new_mode   <= m;
        red        <= r;
        green      <= g;
        blue       <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_tick(input logic lk);
        send_item(KIND_TICK, lk, MODE_W'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic send_mode(input logic [MODE_W-1:0] m);
        send_item(KIND_MODE, 1'($urandom), m, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_direct(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_item(KIND_DIRECT, 1'($urandom), MODE_W'($urandom), r, g, b);
    endtask

    task automatic drain();
        @(negedge clk) push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] zh, input logic [CFG_DATA_W-1:0] zl,
                             input logic [CFG_DATA_W-1:0] oh, input logic [CFG_DATA_W-1:0] ol,
                             input logic [CFG_DATA_W-1:0] latch,
                             input logic [CFG_DATA_W-1:0] per,
                             input logic [CFG_DATA_W-1:0] on);
        drain();
        cfg_write(CFG_ZERO_HIGH, zh);
        cfg_write(CFG_ZERO_LOW, zl);
        cfg_write(CFG_ONE_HIGH, oh);
        cfg_write(CFG_ONE_LOW, ol);
        cfg_write(CFG_LATCH_LOW, latch);
        cfg_write(CFG_BLINK_PERIOD, per);
        cfg_write(CFG_BLINK_ON, on);
        @(negedge clk) cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Most beats are a mode change followed by a run of ticks; the rest are
    // direct colors and spare-kind noise that break up the runs.
    task automatic random_bursts(input int beats);
        int sent;
        int roll;
        int run;
        logic [MODE_W-1:0] m;
        sent = 0;
        while (sent < beats)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                send_item(KIND_SPARE, 1'($urandom), MODE_W'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            end
            else if (roll < 28)
            begin
                send_direct(8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                if ($urandom_range(99) < 70)
                    m = MODE_W'($urandom_range(int'(MODE_SCANNING), int'(MODE_CONNECTED)));
                else
                    m = MODE_W'($urandom);
                send_mode(m);
                sent++;
                run = $urandom_range(2, 10);
                repeat (run)
                begin
                    send_tick($urandom_range(99) < 30);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] per;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_mode(MODE_OFF);
        send_mode(MODE_ERROR);
        send_mode(MODE_READY);
        send_mode(MODE_SPARE6);
        send_tick(1'b0);
        send_mode(MODE_SPARE7);
        send_tick(1'b1);
        send_mode(MODE_SCANNING);
        send_tick(1'b0);
        send_tick(1'b1);
        send_mode(MODE_CONNECTING);
        send_tick(1'b0);
        send_tick(1'b1);
        send_mode(MODE_CONNECTED);
        send_tick(1'b0);
        send_tick(1'b1);
        send_direct(8'h00, 8'h00, 8'h00);
        send_direct(8'hFF, 8'hFF, 8'hFF);
        send_direct(8'hA5, 8'h5A, 8'h3C);
        send_direct(8'hFF, 8'h00, 8'h00);
        send_item(KIND_SPARE, 1'b1, MODE_SPARE7, 8'hFF, 8'hFF, 8'hFF);

        // A short blink period shows the counter wrap and both blink halves.
        drain();
        cfg_write(CFG_BLINK_PERIOD, 16'd3);
        cfg_write(CFG_BLINK_ON, 16'd2);
        @(negedge clk) cfg_we <= 1'b0;
        send_mode(MODE_SCANNING);
        repeat (4) send_tick(1'b0);

        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
        cfg_write(CFG_SPARE, 16'($urandom));
        @(negedge clk) cfg_we <= 1'b0;
        random_bursts(PHASE_BEATS);

        configure(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'd0, 16'hFFFF);
        random_bursts(PHASE_BEATS);

        per = 16'($urandom_range(2, 8));
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), per, 16'($urandom_range(0, int'(per) + 1)));
        random_bursts(PHASE_BEATS);

        per = 16'($urandom_range(1, 20));
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), per, 16'($urandom_range(0, int'(per) + 1)));
        random_bursts(PHASE_BEATS);

        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'd4, 16'd2);
        steady = 1'b1;
        random_bursts(PHASE_BEATS);
        steady = 1'b0;

        drain();
        $display("Run covered %0d input beats, %0d color frames and %0d symbols",
                 sb.beats, sb.frames, sb.symbols_checked);
        $display("under %0d register settings, including period and timing extremes.",
                 settings_used);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
